// ===== design/rls_two_param_estimator_defines.svh =====
// Assertion macros for the two-parameter RLS estimator.
`ifndef RLS_TWO_PARAM_ESTIMATOR_DEFINES_SVH
`define RLS_TWO_PARAM_ESTIMATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define RLS_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RLS_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RLS_CHECK(lbl, prop, msg)
`define RLS_CHECK_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== design/rls_pkg.sv =====
// Shared types, codes and microprogram of the two-parameter RLS estimator.
package rls_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  localparam int PC_BITS = 7;

  // datapath operations
  localparam logic [2:0] OP_EXT = 3'd0;
  localparam logic [2:0] OP_MOV = 3'd1;
  localparam logic [2:0] OP_ADD = 3'd2;
  localparam logic [2:0] OP_SUB = 3'd3;
  localparam logic [2:0] OP_MUL = 3'd4;
  localparam logic [2:0] OP_RCP = 3'd5;

  // register file slots
  localparam logic [3:0] RG_X0 = 4'd0;
  localparam logic [3:0] RG_X1 = 4'd1;
  localparam logic [3:0] RG_P0 = 4'd2;
  localparam logic [3:0] RG_P1 = 4'd3;
  localparam logic [3:0] RG_P2 = 4'd4;
  localparam logic [3:0] RG_P3 = 4'd5;
  localparam logic [3:0] RG_H1 = 4'd6;
  localparam logic [3:0] RG_H2 = 4'd7;
  localparam logic [3:0] RG_Y  = 4'd8;
  localparam logic [3:0] RG_R  = 4'd9;
  localparam logic [3:0] RG_T0 = 4'd10;
  localparam logic [3:0] RG_T1 = 4'd11;
  localparam logic [3:0] RG_T2 = 4'd12;
  localparam logic [3:0] RG_T3 = 4'd13;
  localparam logic [3:0] RG_T4 = 4'd14;
  localparam logic [3:0] RG_T5 = 4'd15;

  // external sources of OP_EXT, carried in the b field
  localparam logic [3:0] EX_H1   = 4'd0;
  localparam logic [3:0] EX_H2   = 4'd1;
  localparam logic [3:0] EX_Y    = 4'd2;
  localparam logic [3:0] EX_R    = 4'd3;
  localparam logic [3:0] EX_I1   = 4'd4;
  localparam logic [3:0] EX_I2   = 4'd5;
  localparam logic [3:0] EX_ONE  = 4'd6;
  localparam logic [3:0] EX_ZERO = 4'd7;

  // configuration register indexes
  localparam logic [1:0] CFG_INIT_ONE = 2'd0;
  localparam logic [1:0] CFG_INIT_TWO = 2'd1;
  localparam logic [1:0] CFG_NOISE    = 2'd2;

  // program entry points
  localparam logic [PC_BITS-1:0] UPD_BASE  = 7'd0;
  localparam logic [PC_BITS-1:0] RST_BASE  = 7'd55;
  localparam logic [PC_BITS-1:0] BOOT_BASE = 7'd61;

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] dst;
    logic [3:0] a;
    logic [3:0] b;
    logic       last;
  } instr_t;

  typedef struct packed {
    logic   capture;
    logic   rd;
    logic   go;
    logic   load_out;
    instr_t instr;
  } cmd_t;

  typedef struct packed {
    logic done;
  } sts_t;

  function automatic instr_t mk(logic [2:0] op, logic [3:0] d, logic [3:0] a,
                                logic [3:0] b, logic last);
    instr_t u;
    u.op = op;
    u.dst = d;
    u.a = a;
    u.b = b;
    u.last = last;
    return u;
  endfunction

  function automatic instr_t ucode(logic [PC_BITS-1:0] pc);
    instr_t u;
    case (pc)
      7'd0:  u = mk(OP_EXT, RG_H1, RG_X0, EX_H1, 1'b0);
      7'd1:  u = mk(OP_EXT, RG_H2, RG_X0, EX_H2, 1'b0);
      7'd2:  u = mk(OP_EXT, RG_Y,  RG_X0, EX_Y,  1'b0);
      7'd3:  u = mk(OP_EXT, RG_R,  RG_X0, EX_R,  1'b0);
      // hP
      7'd4:  u = mk(OP_MUL, RG_T0, RG_H1, RG_P0, 1'b0);
      7'd5:  u = mk(OP_MUL, RG_T1, RG_H2, RG_P2, 1'b0);
      7'd6:  u = mk(OP_ADD, RG_T0, RG_T0, RG_T1, 1'b0);
      7'd7:  u = mk(OP_MUL, RG_T1, RG_H1, RG_P1, 1'b0);
      7'd8:  u = mk(OP_MUL, RG_T2, RG_H2, RG_P3, 1'b0);
      7'd9:  u = mk(OP_ADD, RG_T1, RG_T1, RG_T2, 1'b0);
      // S and 1/S
      7'd10: u = mk(OP_MUL, RG_T0, RG_T0, RG_H1, 1'b0);
      7'd11: u = mk(OP_MUL, RG_T1, RG_T1, RG_H2, 1'b0);
      7'd12: u = mk(OP_ADD, RG_T0, RG_T0, RG_T1, 1'b0);
      7'd13: u = mk(OP_ADD, RG_T0, RG_T0, RG_R,  1'b0);
      7'd14: u = mk(OP_RCP, RG_T0, RG_T0, RG_T0, 1'b0);
      // gain
      7'd15: u = mk(OP_MUL, RG_T1, RG_P0, RG_H1, 1'b0);
      7'd16: u = mk(OP_MUL, RG_T2, RG_P1, RG_H2, 1'b0);
      7'd17: u = mk(OP_ADD, RG_T1, RG_T1, RG_T2, 1'b0);
      7'd18: u = mk(OP_MUL, RG_T1, RG_T1, RG_T0, 1'b0);
      7'd19: u = mk(OP_MUL, RG_T2, RG_P2, RG_H1, 1'b0);
      7'd20: u = mk(OP_MUL, RG_T3, RG_P3, RG_H2, 1'b0);
      7'd21: u = mk(OP_ADD, RG_T2, RG_T2, RG_T3, 1'b0);
      7'd22: u = mk(OP_MUL, RG_T2, RG_T2, RG_T0, 1'b0);
      // innovation and estimate
      7'd23: u = mk(OP_MUL, RG_T3, RG_H1, RG_X0, 1'b0);
      7'd24: u = mk(OP_MUL, RG_T4, RG_H2, RG_X1, 1'b0);
      7'd25: u = mk(OP_ADD, RG_T3, RG_T3, RG_T4, 1'b0);
      7'd26: u = mk(OP_SUB, RG_T3, RG_Y,  RG_T3, 1'b0);
      7'd27: u = mk(OP_MUL, RG_T4, RG_T1, RG_T3, 1'b0);
      7'd28: u = mk(OP_ADD, RG_X0, RG_X0, RG_T4, 1'b0);
      7'd29: u = mk(OP_MUL, RG_T4, RG_T2, RG_T3, 1'b0);
      7'd30: u = mk(OP_ADD, RG_X1, RG_X1, RG_T4, 1'b0);
      // Kh
      7'd31: u = mk(OP_MUL, RG_T0, RG_T1, RG_H1, 1'b0);
      7'd32: u = mk(OP_MUL, RG_T3, RG_T1, RG_H2, 1'b0);
      7'd33: u = mk(OP_MUL, RG_T4, RG_T2, RG_H1, 1'b0);
      7'd34: u = mk(OP_MUL, RG_T5, RG_T2, RG_H2, 1'b0);
      // new covariance, parked in the input slots until all four are done
      7'd35: u = mk(OP_MUL, RG_T1, RG_T0, RG_P0, 1'b0);
      7'd36: u = mk(OP_MUL, RG_T2, RG_T3, RG_P2, 1'b0);
      7'd37: u = mk(OP_ADD, RG_T1, RG_T1, RG_T2, 1'b0);
      7'd38: u = mk(OP_SUB, RG_H1, RG_P0, RG_T1, 1'b0);
      7'd39: u = mk(OP_MUL, RG_T1, RG_T0, RG_P1, 1'b0);
      7'd40: u = mk(OP_MUL, RG_T2, RG_T3, RG_P3, 1'b0);
      7'd41: u = mk(OP_ADD, RG_T1, RG_T1, RG_T2, 1'b0);
      7'd42: u = mk(OP_SUB, RG_H2, RG_P1, RG_T1, 1'b0);
      7'd43: u = mk(OP_MUL, RG_T1, RG_T4, RG_P0, 1'b0);
      7'd44: u = mk(OP_MUL, RG_T2, RG_T5, RG_P2, 1'b0);
      7'd45: u = mk(OP_ADD, RG_T1, RG_T1, RG_T2, 1'b0);
      7'd46: u = mk(OP_SUB, RG_Y,  RG_P2, RG_T1, 1'b0);
      7'd47: u = mk(OP_MUL, RG_T1, RG_T4, RG_P1, 1'b0);
      7'd48: u = mk(OP_MUL, RG_T2, RG_T5, RG_P3, 1'b0);
      7'd49: u = mk(OP_ADD, RG_T1, RG_T1, RG_T2, 1'b0);
      7'd50: u = mk(OP_SUB, RG_R,  RG_P3, RG_T1, 1'b0);
      7'd51: u = mk(OP_MOV, RG_P0, RG_H1, RG_H1, 1'b0);
      7'd52: u = mk(OP_MOV, RG_P1, RG_H2, RG_H2, 1'b0);
      7'd53: u = mk(OP_MOV, RG_P2, RG_Y,  RG_Y,  1'b0);
      7'd54: u = mk(OP_MOV, RG_P3, RG_R,  RG_R,  1'b1);
      // restart
      7'd55: u = mk(OP_EXT, RG_X0, RG_X0, EX_I1,   1'b0);
      7'd56: u = mk(OP_EXT, RG_X1, RG_X0, EX_I2,   1'b0);
      7'd57: u = mk(OP_EXT, RG_P0, RG_X0, EX_ONE,  1'b0);
      7'd58: u = mk(OP_EXT, RG_P1, RG_X0, EX_ZERO, 1'b0);
      7'd59: u = mk(OP_EXT, RG_P2, RG_X0, EX_ZERO, 1'b0);
      7'd60: u = mk(OP_EXT, RG_P3, RG_X0, EX_ONE,  1'b1);
      // state load after reset
      7'd61: u = mk(OP_EXT, RG_X0, RG_X0, EX_ZERO, 1'b0);
      7'd62: u = mk(OP_EXT, RG_X1, RG_X0, EX_ZERO, 1'b0);
      7'd63: u = mk(OP_EXT, RG_P0, RG_X0, EX_ONE,  1'b0);
      7'd64: u = mk(OP_EXT, RG_P1, RG_X0, EX_ZERO, 1'b0);
      7'd65: u = mk(OP_EXT, RG_P2, RG_X0, EX_ZERO, 1'b0);
      7'd66: u = mk(OP_EXT, RG_P3, RG_X0, EX_ONE,  1'b1);
      default: u = mk(OP_MOV, RG_T0, RG_T0, RG_T0, 1'b1);
    endcase
    return u;
  endfunction

endpackage

// ===== design/rls_ctrl.sv =====
// Sequencer: steps the microprogram and drives the datapath commands.
module rls_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_opcode,
  output logic          out_valid,
  input  logic          out_ready,
  output rls_pkg::cmd_t cmd,
  input  rls_pkg::sts_t sts
);
  import rls_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_GO   = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [PC_BITS-1:0] pc_r, pc_nxt;
  logic               boot_r, boot_nxt;
  logic               out_valid_r, out_valid_nxt;
  instr_t             instr;

  assign instr     = ucode(pc_r);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    pc_nxt       = pc_r;
    boot_nxt     = boot_r;
    cmd.capture  = 1'b0;
    cmd.rd       = 1'b0;
    cmd.go       = 1'b0;
    cmd.load_out = 1'b0;
    cmd.instr    = instr;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          pc_nxt      = in_opcode ? RST_BASE : UPD_BASE;
          state_nxt   = S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_GO;
      end
      S_GO, S_WAIT: begin
        cmd.go = (state_r == S_GO);
        if (sts.done) begin
          if (instr.last) begin
            state_nxt = S_FIN;
          end else begin
            pc_nxt    = pc_r + 1'b1;
            state_nxt = S_RD;
          end
        end else begin
          state_nxt = S_WAIT;
        end
      end
      S_FIN: begin
        if (boot_r) begin
          boot_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end else if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RD;
      pc_r        <= BOOT_BASE;
      boot_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      boot_r      <= boot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/rls_dpath.sv =====
// Datapath: register file, saturating adder, split multiplier, reciprocal divider.
module rls_dpath #(
  parameter int WORD_BITS = rls_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = rls_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rls_pkg::cmd_t      cmd,
  output rls_pkg::sts_t      sts,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic signed [31:0] in_regressor_one,
  input  logic signed [31:0] in_regressor_two,
  input  logic signed [31:0] in_measured_value,
  output logic signed [31:0] out_estimate_one,
  output logic signed [31:0] out_estimate_two,
  output logic               out_zero_variance,
  output logic               out_saturated
);
  import rls_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int XW  = (W > 32 ? W : 32) + 1;
  localparam int NW  = (2 * F > W ? 2 * F : W) + 1;
  localparam int MW  = (2 * W + 1 > NW) ? 2 * W + 1 : NW;
  localparam int LB  = (W + 1) / 2;
  localparam int HB  = W - LB;
  localparam int DCW = $clog2(NW + 1);

  localparam logic signed [XW-1:0] MAXX = {{(XW - W + 1){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [XW-1:0] MINX = {{(XW - W + 1){1'b1}}, {(W - 1){1'b0}}};

  // saturate a signed value to the word: {flag, value}
  function automatic logic [W:0] sat(logic signed [XW-1:0] v);
    if (v > MAXX) begin
      return {1'b1, MAXX[W-1:0]};
    end else if (v < MINX) begin
      return {1'b1, MINX[W-1:0]};
    end
    return {1'b0, v[W-1:0]};
  endfunction

  // saturate a magnitude with a sign: {flag, value}
  function automatic logic [W:0] sat_mag(logic neg, logic [MW-1:0] m);
    logic [MW-1:0] lim;
    logic [W-1:0]  mm;
    logic          f;
    lim = (MW'(1) << (W - 1)) - MW'(!neg);
    f   = (m > lim);
    mm  = f ? lim[W-1:0] : m[W-1:0];
    return {f, neg ? (~mm + 1'b1) : mm};
  endfunction

  function automatic logic signed [XW-1:0] sx(logic [W-1:0] v);
    return {{(XW - W){v[W-1]}}, v};
  endfunction

  function automatic logic [W-1:0] mag(logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  // configuration
  logic [31:0] cfg_i1_r, cfg_i2_r;
  logic [30:0] cfg_noise_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_i1_r    <= '0;
      cfg_i2_r    <= '0;
      cfg_noise_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INIT_ONE: cfg_i1_r    <= cfg_data;
        CFG_INIT_TWO: cfg_i2_r    <= cfg_data;
        CFG_NOISE:    cfg_noise_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // captured item fields
  logic [31:0] h1_r, h2_r, y_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      h1_r <= in_regressor_one;
      h2_r <= in_regressor_two;
      y_r  <= in_measured_value;
    end
  end

  // register file, registered read
  logic [W-1:0] rf [16];
  logic [W-1:0] ra_r, rb_r;
  logic         wr_en;
  logic [W-1:0] wd;
  logic         wflag;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rf[cmd.instr.dst] <= wd;
    end
    if (cmd.rd) begin
      ra_r <= rf[cmd.instr.a];
      rb_r <= rf[cmd.instr.b];
    end
  end

  // operations that write back in their issue cycle
  logic signed [XW-1:0] one_x, ext_v, alu_v;
  logic [W:0]           alu_s;
  logic                 is_rcp, rcp_zero, go_alu;

  assign one_x    = XW'(1) << F;
  assign is_rcp   = (cmd.instr.op == OP_RCP);
  assign rcp_zero = (ra_r == '0);
  assign go_alu   = cmd.go && (cmd.instr.op != OP_MUL) && !(is_rcp && !rcp_zero);

  always_comb begin
    case (cmd.instr.b)
      EX_H1:   ext_v = {{(XW - 32){h1_r[31]}}, h1_r};
      EX_H2:   ext_v = {{(XW - 32){h2_r[31]}}, h2_r};
      EX_Y:    ext_v = {{(XW - 32){y_r[31]}}, y_r};
      EX_R:    ext_v = {{(XW - 31){1'b0}}, cfg_noise_r};
      EX_I1:   ext_v = {{(XW - 32){cfg_i1_r[31]}}, cfg_i1_r};
      EX_I2:   ext_v = {{(XW - 32){cfg_i2_r[31]}}, cfg_i2_r};
      EX_ONE:  ext_v = one_x;
      default: ext_v = '0;
    endcase
    case (cmd.instr.op)
      OP_EXT:  alu_v = ext_v;
      OP_ADD:  alu_v = sx(ra_r) + sx(rb_r);
      OP_SUB:  alu_v = sx(ra_r) - sx(rb_r);
      OP_RCP:  alu_v = one_x;
      default: alu_v = sx(ra_r);
    endcase
    alu_s = sat(alu_v);
  end

  // multiplier: magnitude times low half, then high half, then round and saturate
  logic [W-1:0]    ma_r, mb_r;
  logic            mneg_r;
  logic [1:0]      mstep_r;
  logic [W+LB-1:0] plo_r;
  logic [W+HB-1:0] phi_r;
  logic [MW-1:0]   mfull;
  logic [W:0]      mul_s;
  logic            mul_fin;

  assign mul_fin = (mstep_r == 2'd3);
  assign mfull   = (MW'(plo_r) + (MW'(phi_r) << LB) + (MW'(1) << (F - 1))) >> F;
  assign mul_s   = sat_mag(mneg_r, mfull);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mstep_r <= 2'd0;
    end else if (cmd.go && cmd.instr.op == OP_MUL) begin
      mstep_r <= 2'd1;
    end else if (mstep_r != 2'd0) begin
      mstep_r <= mstep_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      ma_r   <= mag(ra_r);
      mb_r   <= mag(rb_r);
      mneg_r <= ra_r[W-1] ^ rb_r[W-1];
    end
    if (mstep_r == 2'd1) begin
      plo_r <= ma_r * mb_r[LB-1:0];
    end
    if (mstep_r == 2'd2) begin
      phi_r <= ma_r * mb_r[W-1:LB];
    end
  end

  // reciprocal: restoring division of 2^(2F) + |S|/2 by |S|, one bit a cycle
  logic           div_busy_r;
  logic [DCW-1:0] dcnt_r;
  logic [NW-1:0]  dn_r;
  logic [W:0]     rem_r;
  logic [W-1:0]   dd_r;
  logic           dneg_r;
  logic [W:0]     trial;
  logic           qbit;
  logic           div_fin;
  logic [W:0]     div_s;
  logic [W-1:0]   ra_mag;

  assign ra_mag  = mag(ra_r);
  assign trial   = {rem_r[W-1:0], dn_r[NW-1]};
  assign qbit    = (trial >= {1'b0, dd_r});
  assign div_fin = div_busy_r && (dcnt_r == '0);
  assign div_s   = sat_mag(dneg_r, MW'(dn_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else if (cmd.go && is_rcp && !rcp_zero) begin
      div_busy_r <= 1'b1;
    end else if (div_fin) begin
      div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go && is_rcp) begin
      dd_r   <= ra_mag;
      dneg_r <= ra_r[W-1];
      dn_r   <= (NW'(1) << (2 * F)) + NW'(ra_mag >> 1);
      rem_r  <= '0;
      dcnt_r <= DCW'(NW);
    end else if (div_busy_r && dcnt_r != '0) begin
      rem_r  <= qbit ? (trial - {1'b0, dd_r}) : trial;
      dn_r   <= {dn_r[NW-2:0], qbit};
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  // write back
  always_comb begin
    if (mul_fin) begin
      {wflag, wd} = mul_s;
    end else if (div_fin) begin
      {wflag, wd} = div_s;
    end else begin
      {wflag, wd} = alu_s;
    end
  end

  assign wr_en    = go_alu || mul_fin || div_fin;
  assign sts.done = wr_en;

  // estimate copies, flags and result register
  logic [W-1:0]         est0_r, est1_r;
  logic                 sat_r, zero_r;
  logic signed [XW-1:0] est0_x, est1_x;

  assign est0_x = sx(est0_r);
  assign est1_x = sx(est1_r);

  always_ff @(posedge clk) begin
    if (wr_en && cmd.instr.dst == RG_X0) begin
      est0_r <= wd;
    end
    if (wr_en && cmd.instr.dst == RG_X1) begin
      est1_r <= wd;
    end
    if (cmd.capture) begin
      sat_r  <= 1'b0;
      zero_r <= 1'b0;
    end else begin
      if (wr_en && wflag) begin
        sat_r <= 1'b1;
      end
      if (cmd.go && is_rcp && rcp_zero) begin
        zero_r <= 1'b1;
      end
    end
    if (cmd.load_out) begin
      out_estimate_one  <= est0_x[31:0];
      out_estimate_two  <= est1_x[31:0];
      out_zero_variance <= zero_r;
      out_saturated     <= sat_r;
    end
  end

endmodule

// ===== design/rls_two_param_estimator.sv =====
// Top level of the two-parameter recursive least squares estimator.
//
//  channel  direction  handshake            payload
//  in_      input      in_valid/in_ready    opcode, regressor_one/two, measured_value
//  out_     output     out_valid/out_ready  estimate_one/two, zero_variance, saturated
//  cfg_     input      cfg_we               cfg_index, cfg_data
//
// One item at a time through a shared datapath. An update item runs 55
// microinstructions: 28 multiplies, 26 moves and adds and one reciprocal.
// Words are Q16.16 by default. After reset a state load runs before the
// first item is taken. A result waiting on out_ready does not hold off the
// next item; only the following finish waits for the slot.
module rls_two_param_estimator #(
  parameter int WORD_BITS = rls_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = rls_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic signed [31:0] in_regressor_one,
  input  logic signed [31:0] in_regressor_two,
  input  logic signed [31:0] in_measured_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_estimate_one,
  output logic signed [31:0] out_estimate_two,
  output logic               out_zero_variance,
  output logic               out_saturated,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import rls_pkg::*;

  `include "rls_two_param_estimator_defines.svh"

  cmd_t cmd;
  sts_t sts;

  rls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  rls_dpath #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_regressor_one  (in_regressor_one),
    .in_regressor_two  (in_regressor_two),
    .in_measured_value (in_measured_value),
    .out_estimate_one  (out_estimate_one),
    .out_estimate_two  (out_estimate_two),
    .out_zero_variance (out_zero_variance),
    .out_saturated     (out_saturated)
  );

  `RLS_CHECK(a_one_item, in_valid && in_ready |=> !in_ready, "second item taken while busy")
  `RLS_CHECK(a_done_busy, sts.done |-> !in_ready, "unit finished while idle")
  `RLS_CHECK(a_out_slot, cmd.load_out |-> (!out_valid || out_ready), "result overwritten")
  `RLS_CHECK_ALWAYS(a_rd_go, !(cmd.rd && cmd.go), "read and issue in one cycle")

endmodule

// ===== verif/rls_two_param_checker.sv =====
// Checker for the two-parameter RLS estimator: predicts each result and compares it.
module rls_two_param_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_opcode,
  input  logic signed [31:0] in_regressor_one,
  input  logic signed [31:0] in_regressor_two,
  input  logic signed [31:0] in_measured_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_estimate_one,
  input  logic signed [31:0] out_estimate_two,
  input  logic               out_zero_variance,
  input  logic               out_saturated,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 pending_count,
  output int                 result_count,
  output int                 zero_var_count,
  output int                 sat_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import rls_pkg::*;

  localparam int FRAC = 16;
  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] est_one;
    logic signed [31:0] est_two;
    logic               zero_var;
    logic               sat;
  } estimate_t;

  estimate_t estimates_due[$];

  longint init_one, init_two, noise;
  longint est[2];
  longint cov[4];
  bit clipped;

  function automatic longint sat_word(longint v);
    if (v > WMAX) begin
      clipped = 1;
      return WMAX;
    end
    if (v < WMIN) begin
      clipped = 1;
      return WMIN;
    end
    return v;
  endfunction

  // exact 128-bit product, round half away from zero, then drop FRAC bits
  function automatic longint qmul(longint a, longint b);
    logic [127:0] mag;
    logic [127:0] ma, mb;
    bit neg;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? 128'(-a) : 128'(a);
    mb = (b < 0) ? 128'(-b) : 128'(b);
    mag = ((ma * mb) + (128'd1 << (FRAC - 1))) >> FRAC;
    if (mag > 128'h8000_0000) begin
      clipped = 1;
      mag = 128'h8000_0000;
    end
    return sat_word(neg ? -longint'(mag) : longint'(mag));
  endfunction

  function automatic longint qadd(longint a, longint b);
    return sat_word(a + b);
  endfunction

  function automatic longint qrecip(longint s);
    longint unsigned us, q;
    us = (s < 0) ? longint'(-s) : longint'(s);
    q = ((64'd1 << (2 * FRAC)) + us / 2) / us;
    if (q > 64'h8000_0000) begin
      clipped = 1;
      q = 64'h8000_0000;
    end
    return sat_word((s < 0) ? -longint'(q) : longint'(q));
  endfunction

  function automatic void load_identity();
    cov[0] = longint'(1) << FRAC;
    cov[1] = 0;
    cov[2] = 0;
    cov[3] = longint'(1) << FRAC;
  endfunction

  function automatic estimate_t rls_update(logic op, longint h1, longint h2, longint y);
    estimate_t r;
    longint hp0, hp1, s, si, k0, k1, e, kh[4], np[4], t;
    clipped = 0;
    r.zero_var = 0;
    if (op) begin
      est[0] = init_one;
      est[1] = init_two;
      load_identity();
    end else begin
      hp0 = qadd(qmul(h1, cov[0]), qmul(h2, cov[2]));
      hp1 = qadd(qmul(h1, cov[1]), qmul(h2, cov[3]));
      s = qadd(qadd(qmul(hp0, h1), qmul(hp1, h2)), noise);
      if (s == 0) begin
        r.zero_var = 1;
        si = longint'(1) << FRAC;
      end else begin
        si = qrecip(s);
      end
      k0 = qmul(qadd(qmul(cov[0], h1), qmul(cov[1], h2)), si);
      k1 = qmul(qadd(qmul(cov[2], h1), qmul(cov[3], h2)), si);
      e = sat_word(y - qadd(qmul(h1, est[0]), qmul(h2, est[1])));
      est[0] = qadd(est[0], qmul(k0, e));
      est[1] = qadd(est[1], qmul(k1, e));
      kh[0] = qmul(k0, h1);
      kh[1] = qmul(k0, h2);
      kh[2] = qmul(k1, h1);
      kh[3] = qmul(k1, h2);
      for (int i = 0; i < 4; i++) begin
        t = qadd(qmul(kh[(i >> 1) * 2], cov[i & 1]),
                 qmul(kh[(i >> 1) * 2 + 1], cov[2 + (i & 1)]));
        np[i] = sat_word(cov[i] - t);
      end
      for (int i = 0; i < 4; i++) cov[i] = np[i];
    end
    r.est_one = est[0][31:0];
    r.est_two = est[1][31:0];
    r.sat = clipped;
    return r;
  endfunction

  assign pending_count = estimates_due.size();

  always @(posedge clk) begin
    estimate_t want, got;
    if (!rst_n) begin
      init_one = 0;
      init_two = 0;
      noise = 0;
      est[0] = 0;
      est[1] = 0;
      load_identity();
      estimates_due.delete();
      fail_count <= 0;
      result_count <= 0;
      zero_var_count <= 0;
      sat_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INIT_ONE: init_one = longint'($signed(cfg_data));
          CFG_INIT_TWO: init_two = longint'($signed(cfg_data));
          CFG_NOISE:    noise = longint'(cfg_data[30:0]);
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        estimates_due.push_back(rls_update(in_opcode, in_regressor_one,
                                           in_regressor_two, in_measured_value));
      if (out_valid && out_ready) begin
        got.est_one = out_estimate_one;
        got.est_two = out_estimate_two;
        got.zero_var = out_zero_variance;
        got.sat = out_saturated;
        result_count <= result_count + 1;
        if (got.zero_var) zero_var_count <= zero_var_count + 1;
        if (got.sat) sat_count <= sat_count + 1;
        if (estimates_due.size() == 0) begin
          if (fail_count < 10) $display("unexpected result est=%h/%h", got.est_one, got.est_two);
          fail_count <= fail_count + 1;
        end else begin
          want = estimates_due.pop_front();
          if (want !== got) begin
            if (fail_count < 10)
              $display("mismatch: exp est=%h/%h zv=%b sat=%b, got est=%h/%h zv=%b sat=%b",
                       want.est_one, want.est_two, want.zero_var, want.sat,
                       got.est_one, got.est_two, got.zero_var, got.sat);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== verif/tb_rls_two_param_estimator.sv =====
// Stimulus and verdict for the two-parameter RLS estimator.
module tb_rls_two_param_estimator;
  timeunit 1ns;
  timeprecision 1ps;
  import rls_pkg::*;

  localparam logic OPC_UPDATE  = 1'b0;
  localparam logic OPC_RESTART = 1'b1;

  logic clk, rst_n;
  logic in_valid, in_ready, in_opcode;
  logic signed [31:0] in_regressor_one, in_regressor_two, in_measured_value;
  logic out_valid, out_ready;
  logic signed [31:0] out_estimate_one, out_estimate_two;
  logic out_zero_variance, out_saturated;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  int fail_count, pending_count, result_count, zero_var_count, sat_count;
  bit calm_sink;
  int sent;

  rls_two_param_estimator uut (.*);
  rls_two_param_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // sink stalls at random, except in calm stretches
  always @(negedge clk)
    out_ready <= calm_sink ? 1'b1 : ($urandom_range(99) >= 32);

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return $urandom;
      default: return 32'($signed($urandom_range(262144)) - 131072);
    endcase
  endfunction

  // drive at the falling edge; back-to-back calls retarget valid in one step
  task automatic send_item(logic op, logic [31:0] h1, logic [31:0] h2, logic [31:0] y,
                           bit gaps);
    if (gaps)
      while ($urandom_range(99) < 32) @(negedge clk);
    in_valid = 1;
    in_opcode = op;
    in_regressor_one = h1;
    in_regressor_two = h2;
    in_measured_value = y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 0;
    sent++;
  endtask

  task automatic drain();
    while (pending_count != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  initial begin
    logic [31:0] h1, h2;
    rst_n = 0;
    in_valid = 0;
    in_opcode = 0;
    in_regressor_one = 0;
    in_regressor_two = 0;
    in_measured_value = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    out_ready = 0;
    calm_sink = 0;
    sent = 0;
    repeat (10) @(negedge clk);
    rst_n = 1;

    // directed: zero variance, extremes, restart, negative noise-free S
    send_item(OPC_UPDATE, 0, 0, 32'h0001_0000, 1);
    send_item(OPC_UPDATE, 32'h0001_0000, 0, 32'h0003_0000, 1);
    send_item(OPC_UPDATE, 0, 32'h0001_0000, 32'hfffe_0000, 1);
    send_item(OPC_UPDATE, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1);
    send_item(OPC_UPDATE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
    send_item(OPC_RESTART, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1);
    send_item(OPC_UPDATE, 32'hffff_ffff, 32'h0000_0001, 32'h5555_aaaa, 1);
    drain();
    write_reg(CFG_INIT_ONE, 32'h7fff_ffff);
    write_reg(CFG_INIT_TWO, 32'h8000_0000);
    write_reg(CFG_NOISE, 32'h7fff_ffff);
    send_item(OPC_RESTART, 0, 0, 0, 1);
    send_item(OPC_UPDATE, 32'h0002_0000, 32'hffff_0000, 32'h0001_0000, 1);
    send_item(OPC_UPDATE, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1);
    drain();
    write_reg(CFG_NOISE, 32'h0);
    write_reg(CFG_INIT_ONE, 32'h8000_0000);
    write_reg(CFG_INIT_TWO, 32'h7fff_ffff);
    send_item(OPC_RESTART, 0, 0, 0, 1);
    send_item(OPC_UPDATE, 32'h0000_8000, 32'h0000_8000, 32'h0000_0000, 1);
    send_item(OPC_UPDATE, 32'hdead_beef, 32'h1234_5678, 32'hcafe_f00d, 1);

    // random phases: each a restart followed by a run of updates with occasional restarts
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_reg(CFG_INIT_ONE, pick_word());
      write_reg(CFG_INIT_TWO, pick_word());
      write_reg(CFG_NOISE, (ph % 3 == 0) ? 32'h0 : 32'($urandom_range(1, 32'h0004_0000)));
      calm_sink = (ph == 4);
      for (int k = 0; k < 150; k++) begin
        if (k == 0 || $urandom_range(99) < 3) begin
          send_item(OPC_RESTART, $urandom, $urandom, $urandom, ph != 4);
        end else begin
          // mostly modest regressors so the estimate converges; some full-range noise
          h1 = ($urandom_range(9) == 0) ? pick_word() : 32'($signed($urandom_range(131072)) - 65536);
          h2 = ($urandom_range(9) == 0) ? pick_word() : 32'($signed($urandom_range(131072)) - 65536);
          send_item(OPC_UPDATE, h1, h2, pick_word(), ph != 4);
        end
        if (k == 75) while (pending_count != 0) @(negedge clk);
      end
    end
    calm_sink = 0;
    drain();

    $display("%0d items sent, %0d results checked, %0d with zero variance, %0d saturated",
             sent, result_count, zero_var_count, sat_count);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
